>>> src/kchs_pkg.sv
// Package: constants, types, the mixing function and the base encoding of the k-mer clock hash sketch.
`timescale 1ns / 1ps
package kchs_pkg;

  localparam int HASH_WORDS_DEF = 8;
  localparam int KLEN_W        = 6;
  localparam int KLEN_MAX      = 32;
  localparam int CTR_W         = 7;
  localparam int HASH_W        = 64;
  localparam int LANES         = 8;
  localparam int ROW_W         = HASH_W * CTR_W;
  localparam int MIX_SHIFT     = 33;

  localparam logic [KLEN_W-1:0] KLEN_RESET = 6'd32;
  localparam logic [63:0] MIX_C1 = 64'hff51afd7ed558ccd;
  localparam logic [63:0] MIX_C2 = 64'hc4ceb9fe1a85ec53;
  localparam logic [31:0] TOTAL_MAX = 32'hFFFF_FFFF;

  localparam logic [7:0] ASCII_C = 8'h43;
  localparam logic [7:0] ASCII_G = 8'h47;
  localparam logic [7:0] ASCII_T = 8'h54;

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_READ = 1'b1;

  typedef struct packed {
    logic push;
    logic rd;
    logic mix1;
    logic mix2;
    logic mix3;
    logic upd;
    logic load_out;
  } kchs_cmd_t;

  typedef struct packed {
    logic count;
    logic last_word;
  } kchs_sts_t;

  function automatic logic [63:0] mix64(input logic [63:0] x);
    logic [63:0] v;
    v = x ^ (x >> MIX_SHIFT);
    v = v * MIX_C1;
    v = v ^ (v >> MIX_SHIFT);
    v = v * MIX_C2;
    v = v ^ (v >> MIX_SHIFT);
    return v;
  endfunction

  function automatic logic [1:0] base_code(input logic [7:0] c);
    logic [1:0] r;
    case (c)
      ASCII_C: r = 2'd1;
      ASCII_G: r = 2'd2;
      ASCII_T: r = 2'd3;
      default: r = 2'd0;
    endcase
    return r;
  endfunction

endpackage

>>> src/kchs_in_if.sv
// Interface: input beat channel of the k-mer clock hash sketch.
`timescale 1ns / 1ps
interface kchs_in_if;
  logic       valid;
  logic       ready;
  logic       operation;
  logic [7:0] base_char;
  logic       new_sequence;
  logic [5:0] read_index;

  modport source (output valid, operation, base_char, new_sequence, read_index, input ready);
  modport sink (input valid, operation, base_char, new_sequence, read_index, output ready);
endinterface

>>> src/kchs_out_if.sv
// Interface: result beat channel of the k-mer clock hash sketch.
`timescale 1ns / 1ps
interface kchs_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] read_data;
  logic [31:0] kmers_seen;

  modport source (output valid, read_data, kmers_seen, input ready);
  modport sink (input valid, read_data, kmers_seen, output ready);
endinterface

>>> src/kchs_datapath.sv
// Datapath: k-mer window, shared mixer, counter memory and result register.
`timescale 1ns / 1ps
module kchs_datapath #(
  parameter int HASH_WORDS = kchs_pkg::HASH_WORDS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [kchs_pkg::KLEN_W-1:0] cfg_data,
  input  logic [7:0]                  in_base_char,
  input  logic                        in_new_sequence,
  input  logic [5:0]                  in_read_index,
  input  kchs_pkg::kchs_cmd_t         cmd,
  output kchs_pkg::kchs_sts_t         sts,
  output logic [63:0]                 out_read_data,
  output logic [31:0]                 out_kmers_seen
);

  localparam int RW = (HASH_WORDS > 1) ? $clog2(HASH_WORDS) : 1;
  localparam int ROW_W = kchs_pkg::ROW_W;
  localparam int CTR_W = kchs_pkg::CTR_W;

  logic [63:0] seed [HASH_WORDS];

  for (genvar gi = 0; gi < HASH_WORDS; gi++) begin : g_seed
    localparam logic [63:0] SEED_W = kchs_pkg::mix64(64'(gi + 1));
    assign seed[gi] = SEED_W;
  end

  logic [kchs_pkg::KLEN_W-1:0] klen_r;
  logic [63:0]                 window_r;
  logic [5:0]                  fill_r;
  logic [31:0]                 total_r;
  logic [RW-1:0]               w_r;
  logic [HASH_WORDS-1:0]       vld_r;
  logic [ROW_W-1:0]            mem [HASH_WORDS];
  logic [ROW_W-1:0]            rd_row_r;
  logic                        rd_vld_r;
  logic [2:0]                  rd_sel_r;
  logic                        rd_ok_r;
  logic [63:0]                 p0_r;
  logic [31:0]                 p1_r;
  logic [31:0]                 p2_r;
  logic [63:0]                 h_r;
  logic [63:0]                 out_data_r;
  logic [31:0]                 out_seen_r;

  logic [5:0]       k_eff;
  logic [6:0]       ins_shift;
  logic [63:0]      kmask;
  logic [63:0]      window_base;
  logic [63:0]      window_nxt;
  logic [5:0]       fill_base;
  logic [5:0]       fill_nxt;
  logic [63:0]      x0;
  logic [63:0]      sum;
  logic [63:0]      fold;
  logic [63:0]      mul_x;
  logic [63:0]      mul_c;
  logic [63:0]      prod0;
  logic [31:0]      prod1;
  logic [31:0]      prod2;
  logic [ROW_W-1:0] new_row;
  logic [2:0]       rq_row;
  logic [RW-1:0]    rq_addr;
  logic             rq_ok;
  logic [63:0]      out_data_nxt;

  always_comb begin
    if (klen_r == '0) begin
      k_eff = 6'd1;
    end else if (klen_r > 6'(kchs_pkg::KLEN_MAX)) begin
      k_eff = 6'(kchs_pkg::KLEN_MAX);
    end else begin
      k_eff = klen_r;
    end
    ins_shift = {k_eff - 6'd1, 1'b0};
    kmask = (k_eff == 6'(kchs_pkg::KLEN_MAX)) ? '1 : ((64'd1 << {k_eff, 1'b0}) - 64'd1);
    window_base = in_new_sequence ? '0 : window_r;
    fill_base = in_new_sequence ? '0 : fill_r;
    window_nxt = ((window_base >> 2) |
                  (64'(kchs_pkg::base_code(in_base_char)) << ins_shift)) & kmask;
    fill_nxt = (fill_base < k_eff) ? fill_base + 6'd1 : fill_base;
  end

  assign sts.count = (fill_nxt >= k_eff);
  assign sts.last_word = (int'(w_r) == HASH_WORDS - 1);

  always_comb begin
    x0 = seed[w_r] ^ window_r;
    sum = p0_r + {p1_r + p2_r, 32'd0};
    fold = sum ^ (sum >> kchs_pkg::MIX_SHIFT);
    if (cmd.mix1) begin
      mul_x = x0 ^ (x0 >> kchs_pkg::MIX_SHIFT);
      mul_c = kchs_pkg::MIX_C1;
    end else begin
      mul_x = fold;
      mul_c = kchs_pkg::MIX_C2;
    end
    prod0 = mul_x[31:0] * mul_c[31:0];
    prod1 = mul_x[63:32] * mul_c[31:0];
    prod2 = mul_x[31:0] * mul_c[63:32];
  end

  always_comb begin
    for (int i = 0; i < kchs_pkg::HASH_W; i++) begin
      new_row[i*CTR_W +: CTR_W] = (rd_vld_r ? rd_row_r[i*CTR_W +: CTR_W] : '0) +
                                   CTR_W'(h_r[i]);
    end
  end

  assign rq_row = in_read_index[5:3];
  assign rq_addr = RW'(rq_row);
  assign rq_ok = (int'(rq_row) < HASH_WORDS);

  always_comb begin
    for (int j = 0; j < kchs_pkg::LANES; j++) begin
      out_data_nxt[j*8 +: 8] = (rd_ok_r && rd_vld_r) ?
                               {1'b0, rd_row_r[(int'(rd_sel_r) + 8*j)*CTR_W +: CTR_W]} : 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      klen_r <= kchs_pkg::KLEN_RESET;
      window_r <= '0;
      fill_r <= '0;
      total_r <= '0;
      w_r <= '0;
      vld_r <= '0;
    end else begin
      if (cfg_we) begin
        klen_r <= cfg_data;
        window_r <= '0;
        fill_r <= '0;
      end else if (cmd.push) begin
        window_r <= window_nxt;
        fill_r <= fill_nxt;
        w_r <= '0;
        if (sts.count && total_r != kchs_pkg::TOTAL_MAX) begin
          total_r <= total_r + 32'd1;
        end
      end
      if (cmd.upd) begin
        vld_r[w_r] <= 1'b1;
        if (!sts.last_word) begin
          w_r <= w_r + RW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mix1 || cmd.mix2) begin
      p0_r <= prod0;
      p1_r <= prod1;
      p2_r <= prod2;
    end
    if (cmd.mix3) begin
      h_r <= fold;
      rd_row_r <= mem[w_r];
      rd_vld_r <= vld_r[w_r];
    end else if (cmd.rd) begin
      rd_row_r <= mem[rq_addr];
      rd_vld_r <= vld_r[rq_addr];
      rd_sel_r <= in_read_index[2:0];
      rd_ok_r <= rq_ok;
    end
    if (cmd.upd) begin
      mem[w_r] <= new_row;
    end
    if (cmd.load_out) begin
      out_data_r <= out_data_nxt;
      out_seen_r <= total_r;
    end
  end

  assign out_read_data = out_data_r;
  assign out_kmers_seen = out_seen_r;

endmodule

>>> src/kchs_ctrl.sv
// Controller: sequences pushes, hash words and reads of the k-mer clock hash sketch.
`timescale 1ns / 1ps
module kchs_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_operation,
  output logic                out_valid,
  input  logic                out_ready,
  input  kchs_pkg::kchs_sts_t sts,
  output kchs_pkg::kchs_cmd_t cmd
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_RDOUT = 3'd1;
  localparam logic [2:0] ST_MIX1  = 3'd2;
  localparam logic [2:0] ST_MIX2  = 3'd3;
  localparam logic [2:0] ST_MIX3  = 3'd4;
  localparam logic [2:0] ST_UPD   = 3'd5;

  logic [2:0] state_r;
  logic [2:0] state_nxt;
  logic       out_valid_r;
  logic       out_valid_nxt;
  logic       accept;
  logic       slot_free;

  assign in_ready = (state_r == ST_IDLE);
  assign accept = in_valid && in_ready;
  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    cmd = '0;
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_operation == kchs_pkg::OP_READ) begin
            cmd.rd = 1'b1;
            state_nxt = ST_RDOUT;
          end else begin
            cmd.push = 1'b1;
            if (sts.count) begin
              state_nxt = ST_MIX1;
            end
          end
        end
      end
      ST_RDOUT: begin
        if (slot_free) begin
          cmd.load_out = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      ST_MIX1: begin
        cmd.mix1 = 1'b1;
        state_nxt = ST_MIX2;
      end
      ST_MIX2: begin
        cmd.mix2 = 1'b1;
        state_nxt = ST_MIX3;
      end
      ST_MIX3: begin
        cmd.mix3 = 1'b1;
        state_nxt = ST_UPD;
      end
      ST_UPD: begin
        cmd.upd = 1'b1;
        state_nxt = sts.last_word ? ST_IDLE : ST_MIX1;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  a_push_starts_mix : assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.push && sts.count) |=> (state_r == ST_MIX1))
    else $error("counted k-mer did not start hashing");

  a_load_into_free_slot : assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> slot_free)
    else $error("result loaded over a pending beat");

  a_last_word_ends : assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.upd && sts.last_word) |=> (state_r == ST_IDLE))
    else $error("hashing ran past the last word");

  a_read_yields_beat : assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |=> out_valid_r)
    else $error("loaded result not presented");

endmodule

>>> src/kmer_clock_hash_sketch.sv
// Top level: k-mer clock hash counting sketch.
`timescale 1ns / 1ps
// Bases enter one beat at a time. A push whose k-mer is not yet complete only updates the window;
// a push that completes a k-mer then sends each hash word through one shared mixer (two 64-bit
// multiplies, each built from three 32x32 products) and one read-modify-write of its 448-bit counter
// row in memory, taking no new beat until the last word is written. A read registers its row,
// then loads the result once the result channel has room; the next beat is taken once the result
// is loaded. Counter rows are cleared by per-row valid bits at reset, so no clearing pass is needed.
module kmer_clock_hash_sketch #(
  parameter int HASH_WORDS = kchs_pkg::HASH_WORDS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [kchs_pkg::KLEN_W-1:0] cfg_data,
  kchs_in_if.sink                     in_bus,
  kchs_out_if.source                  out_bus
);

  kchs_pkg::kchs_cmd_t cmd;
  kchs_pkg::kchs_sts_t sts;

  kchs_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_bus.valid),
    .in_ready     (in_bus.ready),
    .in_operation (in_bus.operation),
    .out_valid    (out_bus.valid),
    .out_ready    (out_bus.ready),
    .sts          (sts),
    .cmd          (cmd)
  );

  kchs_datapath #(
    .HASH_WORDS (HASH_WORDS)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_data        (cfg_data),
    .in_base_char    (in_bus.base_char),
    .in_new_sequence (in_bus.new_sequence),
    .in_read_index   (in_bus.read_index),
    .cmd             (cmd),
    .sts             (sts),
    .out_read_data   (out_bus.read_data),
    .out_kmers_seen  (out_bus.kmers_seen)
  );

endmodule
